// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/ppsf_pkg.sv =====
// Shared types and constants for the ping-pong sample framer.
`default_nettype none

package ppsf_pkg;

   localparam int DEF_MAX_SAMPLES = 64;

   localparam int OP_W     = 3;
   localparam int SAMPLE_W = 16;
   localparam int WORD_W   = 32;
   localparam int SPF_W    = 7;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAILER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPF     = 2'd2;

   localparam logic [WORD_W-1:0] HEADER_RESET  = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] TRAILER_RESET = 32'hDEAD_BEEF;
   localparam logic [SPF_W-1:0]  SPF_RESET     = 7'd40;

   typedef enum logic [OP_W-1:0] {
      OP_FRAME  = 3'd0,
      OP_SUB    = 3'd1,
      OP_CMP    = 3'd2,
      OP_SAMPLE = 3'd3,
      OP_POLL   = 3'd4,
      OP_OVF    = 3'd5,
      OP_DONE   = 3'd6
   } op_type;

   typedef struct packed {
      logic [WORD_W-1:0] header_word;
      logic [WORD_W-1:0] trailer_word;
   } cfg_type;

   typedef struct packed {
      logic              is_packet_word;
      logic [WORD_W-1:0] packet_word;
      logic              last;
      logic              ir_led;
      logic              amp_reset;
      logic              start_conversion;
      logic              busy_led;
      logic              sampling_on;
      logic [1:0]        full_flags;
      logic              sending;
      logic              halted;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/ppsf_if.sv =====
// Request and response channel interfaces.
`default_nettype none

interface ppsf_req_if;
   import ppsf_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output op, output sample, input ready);
   modport sink (input valid, input op, input sample, output ready);
endinterface

interface ppsf_rsp_if;
   import ppsf_pkg::*;

   logic              valid;
   logic              ready;
   logic              is_packet_word;
   logic [WORD_W-1:0] packet_word;
   logic              last;
   logic              ir_led;
   logic              amp_reset;
   logic              start_conversion;
   logic              busy_led;
   logic              sampling_on;
   logic [1:0]        full_flags;
   logic              sending;
   logic              halted;

   modport source (
      output valid, output is_packet_word, output packet_word, output last,
      output ir_led, output amp_reset, output start_conversion, output busy_led,
      output sampling_on, output full_flags, output sending, output halted,
      input ready
   );
   modport sink (
      input valid, input is_packet_word, input packet_word, input last,
      input ir_led, input amp_reset, input start_conversion, input busy_led,
      input sampling_on, input full_flags, input sending, input halted,
      output ready
   );
endinterface

`default_nettype wire

// ===== hdl/ppsf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ppsf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hdl/ppsf_csr.sv =====
// Configuration registers and effective frame length.
`default_nettype none

module ppsf_csr #(
   parameter int MAX_SAMPLES = ppsf_pkg::DEF_MAX_SAMPLES,
   localparam int CNT_W = $clog2(MAX_SAMPLES + 2)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [ppsf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ppsf_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output      ppsf_pkg::cfg_type                   cfg,
   output      logic [CNT_W-1:0]                    frame_len
);

   import ppsf_pkg::*;

   logic [WORD_W-1:0] header_ff;
   logic [WORD_W-1:0] trailer_ff;
   logic [SPF_W-1:0]  spf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= HEADER_RESET;
         trailer_ff <= TRAILER_RESET;
         spf_ff     <= SPF_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_HEADER) begin
            header_ff <= csr_wdata;
         end
         if (csr_index == CSR_TRAILER) begin
            trailer_ff <= csr_wdata;
         end
         if (csr_index == CSR_SPF) begin
            spf_ff <= csr_wdata[SPF_W-1:0];
         end
      end
   end

   // clamp to 1..MAX_SAMPLES
   always_comb begin
      priority if (spf_ff == '0) begin
         frame_len = CNT_W'(1);
      end else if (spf_ff > SPF_W'(MAX_SAMPLES)) begin
         frame_len = CNT_W'(MAX_SAMPLES);
      end else begin
         frame_len = CNT_W'(spf_ff);
      end
   end

   assign cfg.header_word  = header_ff;
   assign cfg.trailer_word = trailer_ff;

endmodule

`default_nettype wire

// ===== hdl/ppsf_ctrl.sv =====
// Sequencer: applies requests, fills the sample RAM and streams packets out of it.
`default_nettype none

module ppsf_ctrl #(
   parameter int MAX_SAMPLES = ppsf_pkg::DEF_MAX_SAMPLES,
   localparam int SIDX_W = $clog2(MAX_SAMPLES),
   localparam int ADDR_W = SIDX_W + 1,
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 2)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ppsf_pkg::cfg_type             cfg,
   input  wire logic [CNT_W-1:0]              frame_len,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [ppsf_pkg::OP_W-1:0]     req_op,
   input  wire logic [ppsf_pkg::SAMPLE_W-1:0] req_sample,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      ppsf_pkg::rsp_type             rsp_data,
   output      logic                          mem_we,
   output      logic [ADDR_W-1:0]             mem_waddr,
   output      logic [ppsf_pkg::SAMPLE_W-1:0] mem_wdata,
   output      logic                          mem_re,
   output      logic [ADDR_W-1:0]             mem_raddr,
   input  wire logic [ppsf_pkg::SAMPLE_W-1:0] mem_rdata
);

   import ppsf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_STAT,
      S_HDR,
      S_LO,
      S_HI,
      S_TRAIL
   } state_type;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [SAMPLE_W-1:0] smp_ff, smp_in;
   logic [SIDX_W-1:0]   fill_idx_ff, fill_idx_in;
   logic                fill_buf_ff, fill_buf_in;
   logic [1:0]          full_ff, full_in;
   logic                send_ff, send_in;
   logic                gate_ff, gate_in;
   logic                ir_ff, ir_in;
   logic                amp_ff, amp_in;
   logic                bled_ff, bled_in;
   logic                frozen_ff, frozen_in;
   logic                sc_ff, sc_in;
   logic                sbuf_ff, sbuf_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [SAMPLE_W-1:0] lo_ff, lo_in;
   logic                hi_ok_ff, hi_ok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                out_free;
   logic [CNT_W-1:0]    fill_next;
   logic                poll_buf;
   rsp_type             rsp_base;
   logic [SAMPLE_W-1:0] hi_word;

   function automatic logic [ADDR_W-1:0] mk_addr(input logic buf_sel,
                                                 input logic [SIDX_W-1:0] idx);
      logic [ADDR_W-1:0] base;
      base = buf_sel ? ADDR_W'(MAX_SAMPLES) : '0;
      return base + ADDR_W'(idx);
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fill_next = CNT_W'(fill_idx_ff) + CNT_W'(1);
   assign poll_buf  = !full_ff[0];
   assign hi_word   = hi_ok_ff ? mem_rdata : '0;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      rsp_base                  = '0;
      rsp_base.ir_led           = ir_ff;
      rsp_base.amp_reset        = amp_ff;
      rsp_base.busy_led         = bled_ff;
      rsp_base.sampling_on      = gate_ff;
      rsp_base.full_flags       = full_ff;
      rsp_base.sending          = send_ff;
      rsp_base.halted           = frozen_ff;

      state_in     = state_ff;
      op_in        = op_ff;
      smp_in       = smp_ff;
      fill_idx_in  = fill_idx_ff;
      fill_buf_in  = fill_buf_ff;
      full_in      = full_ff;
      send_in      = send_ff;
      gate_in      = gate_ff;
      ir_in        = ir_ff;
      amp_in       = amp_ff;
      bled_in      = bled_ff;
      frozen_in    = frozen_ff;
      sc_in        = sc_ff;
      sbuf_in      = sbuf_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_ok_in     = hi_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      mem_we    = 1'b0;
      mem_waddr = mk_addr(fill_buf_ff, fill_idx_ff);
      mem_wdata = smp_ff;
      mem_re    = 1'b0;
      mem_raddr = mk_addr(sbuf_ff, idx_ff[SIDX_W-1:0]);

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = op_type'(req_op);
               smp_in   = req_sample;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            sc_in    = 1'b0;
            state_in = S_STAT;
            if (!frozen_ff) begin
               unique case (op_ff)
                  OP_FRAME: begin
                     ir_in   = 1'b1;
                     amp_in  = 1'b0;
                     gate_in = 1'b1;
                  end
                  OP_SUB: begin
                     if (gate_ff) begin
                        ir_in  = 1'b1;
                        amp_in = 1'b0;
                     end
                  end
                  OP_CMP: begin
                     if (gate_ff) begin
                        sc_in   = 1'b1;
                        bled_in = 1'b1;
                     end
                  end
                  OP_SAMPLE: begin
                     mem_we  = 1'b1;
                     bled_in = 1'b0;
                     ir_in   = 1'b0;
                     amp_in  = 1'b1;
                     if (fill_next >= frame_len) begin
                        full_in[fill_buf_ff] = 1'b1;
                        fill_idx_in          = '0;
                        fill_buf_in          = !fill_buf_ff;
                        gate_in              = 1'b0;
                     end else begin
                        fill_idx_in = fill_next[SIDX_W-1:0];
                     end
                  end
                  OP_POLL: begin
                     if (!send_ff && full_ff != 2'b00) begin
                        full_in[poll_buf] = 1'b0;
                        send_in           = 1'b1;
                        sbuf_in           = poll_buf;
                        state_in          = S_HDR;
                     end
                  end
                  OP_OVF: begin
                     if (full_ff == 2'b11) begin
                        frozen_in = 1'b1;
                     end
                  end
                  OP_DONE: begin
                     send_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_STAT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_in                  = rsp_base;
               rsp_in.last             = 1'b1;
               rsp_in.start_conversion = sc_ff;
               state_in                = S_IDLE;
            end
         end
         S_HDR: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in                = rsp_base;
               rsp_in.is_packet_word = 1'b1;
               rsp_in.packet_word    = cfg.header_word;
               mem_re                = 1'b1;
               mem_raddr             = mk_addr(sbuf_ff, '0);
               idx_in                = CNT_W'(1);
               state_in              = S_LO;
            end
         end
         S_LO: begin
            // low half is in; fetch the high half if the frame has one
            lo_in    = mem_rdata;
            hi_ok_in = (idx_ff < frame_len);
            mem_re   = (idx_ff < frame_len);
            idx_in   = idx_ff + CNT_W'(1);
            state_in = S_HI;
         end
         S_HI: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in                = rsp_base;
               rsp_in.is_packet_word = 1'b1;
               rsp_in.packet_word    = {hi_word, lo_ff};
               if (idx_ff >= frame_len) begin
                  state_in = S_TRAIL;
               end else begin
                  mem_re   = 1'b1;
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = S_LO;
               end
            end
         end
         S_TRAIL: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in                = rsp_base;
               rsp_in.is_packet_word = 1'b1;
               rsp_in.packet_word    = cfg.trailer_word;
               rsp_in.last           = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      smp_ff   <= smp_in;
      sc_ff    <= sc_in;
      sbuf_ff  <= sbuf_in;
      idx_ff   <= idx_in;
      lo_ff    <= lo_in;
      hi_ok_ff <= hi_ok_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_idx_ff  <= '0;
         fill_buf_ff  <= 1'b0;
         full_ff      <= 2'b00;
         send_ff      <= 1'b0;
         gate_ff      <= 1'b1;
         ir_ff        <= 1'b0;
         amp_ff       <= 1'b0;
         bled_ff      <= 1'b0;
         frozen_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_idx_ff  <= fill_idx_in;
         fill_buf_ff  <= fill_buf_in;
         full_ff      <= full_in;
         send_ff      <= send_in;
         gate_ff      <= gate_in;
         ir_ff        <= ir_in;
         amp_ff       <= amp_in;
         bled_ff      <= bled_in;
         frozen_ff    <= frozen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/ping_pong_sample_framer.sv =====
// Top level of the ping-pong sample framer.
`default_nettype none
`include "assert_macros.svh"

// Ping-pong sample framer. Requests carry an op (frame tick, sub tick,
// compare match, sample done, send poll, overflow check, send done) and a
// 16-bit sample. Samples fill two buffers in turn inside one sample RAM of
// 2 x MAX_SAMPLES entries; a full buffer is flagged and sampling stops until
// the next frame tick. A send poll with no send in flight streams the
// lowest-numbered full buffer as header, sample pairs (lower sample in bits
// 15..0, high half zero for an odd tail) and trailer; every other request
// gives one status response with last set. Every response carries pin levels
// and status after the request is applied. Requests are handled one at a
// time; a request is taken while the previous response still waits in
// the output register. A request is taken in S_IDLE, applied in S_EXEC,
// and its status response is registered in S_STAT; a send poll with n
// samples gives 2 + ceil(n/2) words: the header from S_HDR, then one pair
// word per S_LO, S_HI round, since the single RAM read port fetches both
// halves of each pair in turn, and the trailer from S_TRAIL. Back-pressure
// stalls S_STAT, S_HDR, S_HI and S_TRAIL. The sample RAM has no reset;
// a packet may read entries never written only if samples_per_frame is
// raised while buffers fill. Config writes (csr_*) belong in idle periods.
module ping_pong_sample_framer #(
   parameter int MAX_SAMPLES = ppsf_pkg::DEF_MAX_SAMPLES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [ppsf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ppsf_pkg::CSR_DATA_W-1:0] csr_wdata,
   ppsf_req_if.sink                             req_ch,
   ppsf_rsp_if.source                           rsp_ch
);

   import ppsf_pkg::*;

   localparam int SIDX_W = $clog2(MAX_SAMPLES);
   localparam int ADDR_W = SIDX_W + 1;
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 2);
   localparam int DEPTH  = 2 * MAX_SAMPLES;

   cfg_type             cfg;
   logic [CNT_W-1:0]    frame_len;

   // sample RAM port
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [SAMPLE_W-1:0] mem_wdata;
   logic                mem_re;
   logic [ADDR_W-1:0]   mem_raddr;
   logic [SAMPLE_W-1:0] mem_rdata;

   logic                rsp_valid;
   rsp_type             rsp_data;

   ppsf_csr #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .frame_len (frame_len)
   );

   ppsf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   ppsf_ctrl #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .frame_len  (frame_len),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_op     (req_ch.op),
      .req_sample (req_ch.sample),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_data   (rsp_data),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   // response channel
   assign rsp_ch.valid            = rsp_valid;
   assign rsp_ch.is_packet_word   = rsp_data.is_packet_word;
   assign rsp_ch.packet_word      = rsp_data.packet_word;
   assign rsp_ch.last             = rsp_data.last;
   assign rsp_ch.ir_led           = rsp_data.ir_led;
   assign rsp_ch.amp_reset        = rsp_data.amp_reset;
   assign rsp_ch.start_conversion = rsp_data.start_conversion;
   assign rsp_ch.busy_led         = rsp_data.busy_led;
   assign rsp_ch.sampling_on      = rsp_data.sampling_on;
   assign rsp_ch.full_flags       = rsp_data.full_flags;
   assign rsp_ch.sending          = rsp_data.sending;
   assign rsp_ch.halted           = rsp_data.halted;

   // halt only happens with both buffers full, and nothing moves afterwards
   `ASSERT_IMPLY(a_halt_full, clock, reset, rsp_valid && rsp_data.halted,
                 rsp_data.full_flags == 2'b11)

   // halt is sticky
   `ASSERT_NEXT(a_halt_sticky, clock, reset, rsp_valid && rsp_data.halted,
                !rsp_valid || rsp_data.halted)

   // packet words only go out while a send is marked in progress
   `ASSERT_IMPLY(a_pkt_sending, clock, reset, rsp_valid && rsp_data.is_packet_word,
                 rsp_data.sending)

   // a conversion start is a lone status response with the busy indicator on
   `ASSERT_IMPLY(a_start_conv, clock, reset, rsp_valid && rsp_data.start_conversion,
                 !rsp_data.is_packet_word && rsp_data.last && rsp_data.busy_led &&
                 rsp_data.sampling_on && rsp_data.packet_word == '0)

endmodule

`default_nettype wire

// ===== tb/sv/ping_pong_sample_framer_tb.sv =====
// Self-checking testbench for the ping-pong sample framer.
module ping_pong_sample_framer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ppsf_pkg::*;

   localparam int MAX_SAMPLES = DEF_MAX_SAMPLES;

   // Register index with no register behind it; writes must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   // Op code with no meaning; the block answers with a plain status response.
   localparam logic [OP_W-1:0] OP_UNDEF = 3'd7;

   // Hang guard. Worst case is a few hundred requests, each a 34-word packet
   // with every word sitting out the longest stall, plus one long hold-off.
   localparam int CYCLE_LIMIT = 800_000;
   // Slack after the last response.
   localparam int SETTLE_CYCLES = 20;
   // Length of the one long response hold-off that backs up the block.
   localparam int LONG_HOLD_CYCLES = 300;

   // Tracks the framer's state and the responses each request must cause.
   class framer_tracker;
      logic [SAMPLE_W-1:0] store [2*MAX_SAMPLES];
      bit                  written [2*MAX_SAMPLES];
      logic [WORD_W-1:0]   header_word;
      logic [WORD_W-1:0]   trailer_word;
      logic [SPF_W-1:0]    spf;
      logic [6:0]          fill_index;
      logic                fill_buffer;
      logic [1:0]          full_bits;
      logic                send_busy;
      logic                gate_open;
      logic                ir_led;
      logic                amp_reset;
      logic                busy_led;
      logic                frozen;
      rsp_type             due[$];
      int                  mismatches;

      function new();
         header_word  = HEADER_RESET;
         trailer_word = TRAILER_RESET;
         spf          = SPF_RESET;
         fill_index   = '0;
         fill_buffer  = 1'b0;
         full_bits    = 2'b00;
         send_busy    = 1'b0;
         gate_open    = 1'b1;
         ir_led       = 1'b0;
         amp_reset    = 1'b0;
         busy_led     = 1'b0;
         frozen       = 1'b0;
         mismatches   = 0;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      // Samples per buffer after clamping to 1..MAX_SAMPLES.
      function int frame_len();
         int n;
         n = int'(spf);
         if (n == 0) n = 1;
         if (n > MAX_SAMPLES) n = MAX_SAMPLES;
         return n;
      endfunction

      function int slot(int buf_sel, int idx);
         return buf_sel * MAX_SAMPLES + idx % MAX_SAMPLES;
      endfunction

      // Queue one response carrying the current status.
      function void push_result(logic isw, logic [WORD_W-1:0] word, logic last_flag,
                                logic sc);
         rsp_type r;
         r.is_packet_word   = isw;
         r.packet_word      = word;
         r.last             = last_flag;
         r.ir_led           = ir_led;
         r.amp_reset        = amp_reset;
         r.start_conversion = sc;
         r.busy_led         = busy_led;
         r.sampling_on      = gate_open;
         r.full_flags       = full_bits;
         r.sending          = send_busy;
         r.halted           = frozen;
         due.push_back(r);
      endfunction

      // True when a poll now would read only stored sample entries.
      function bit poll_is_safe();
         int b;
         if (frozen || send_busy || full_bits == 2'b00) return 1'b1;
         b = full_bits[0] ? 0 : 1;
         for (int i = 0; i < frame_len(); i++)
            if (!written[slot(b, i)]) return 1'b0;
         return 1'b1;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_HEADER:  header_word  = data[WORD_W-1:0];
            CSR_TRAILER: trailer_word = data[WORD_W-1:0];
            CSR_SPF:     spf          = data[SPF_W-1:0];
            default: ;
         endcase
      endfunction

      // Apply one accepted request and queue the responses it causes.
      function void take_request(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] smp);
         logic                sc;
         logic [SAMPLE_W-1:0] lo;
         logic [SAMPLE_W-1:0] hi;
         int                  a;
         int                  b;
         int                  n;
         sc = 1'b0;
         if (frozen) begin
            push_result(1'b0, '0, 1'b1, 1'b0);
            return;
         end
         case (op)
            OP_FRAME: begin
               ir_led    = 1'b1;
               amp_reset = 1'b0;
               gate_open = 1'b1;
            end
            OP_SUB: if (gate_open) begin
               ir_led    = 1'b1;
               amp_reset = 1'b0;
            end
            OP_CMP: if (gate_open) begin
               sc       = 1'b1;
               busy_led = 1'b1;
            end
            OP_SAMPLE: begin
               // stored even with the gate closed
               a = slot(int'(fill_buffer), int'(fill_index));
               store[a]   = smp;
               written[a] = 1'b1;
               busy_led   = 1'b0;
               ir_led     = 1'b0;
               amp_reset  = 1'b1;
               fill_index = fill_index + 7'd1;
               if (int'(fill_index) >= frame_len()) begin
                  full_bits[fill_buffer] = 1'b1;
                  fill_index  = '0;
                  fill_buffer = ~fill_buffer;
                  gate_open   = 1'b0;
               end
            end
            OP_POLL: begin
               if (!send_busy && full_bits != 2'b00) begin
                  b = full_bits[0] ? 0 : 1;
                  n = frame_len();
                  full_bits[b] = 1'b0;
                  send_busy    = 1'b1;
                  push_result(1'b1, header_word, 1'b0, 1'b0);
                  for (int p = 0; p < (n + 1) / 2; p++) begin
                     lo = store[slot(b, 2 * p)];
                     hi = (2 * p + 1 < n) ? store[slot(b, 2 * p + 1)] : '0;
                     push_result(1'b1, {hi, lo}, 1'b0, 1'b0);
                  end
                  push_result(1'b1, trailer_word, 1'b1, 1'b0);
                  return;
               end
            end
            OP_OVF: if (full_bits == 2'b11) frozen = 1'b1;
            OP_DONE: send_busy = 1'b0;
            default: ;
         endcase
         push_result(1'b0, '0, 1'b1, sc);
      endfunction

      function void check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
         if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
         end
      endfunction

      function void match_response(rsp_type got);
         rsp_type want;
         if (due.size() == 0) begin
            $error("unexpected response: word %h last %b", got.packet_word, got.last);
            mismatches++;
            return;
         end
         want = due.pop_front();
         check_field("is_packet_word", WORD_W'(want.is_packet_word),
                     WORD_W'(got.is_packet_word));
         check_field("packet_word", want.packet_word, got.packet_word);
         check_field("last", WORD_W'(want.last), WORD_W'(got.last));
         check_field("ir_led", WORD_W'(want.ir_led), WORD_W'(got.ir_led));
         check_field("amp_reset", WORD_W'(want.amp_reset), WORD_W'(got.amp_reset));
         check_field("start_conversion", WORD_W'(want.start_conversion),
                     WORD_W'(got.start_conversion));
         check_field("busy_led", WORD_W'(want.busy_led), WORD_W'(got.busy_led));
         check_field("sampling_on", WORD_W'(want.sampling_on), WORD_W'(got.sampling_on));
         check_field("full_flags", WORD_W'(want.full_flags), WORD_W'(got.full_flags));
         check_field("sending", WORD_W'(want.sending), WORD_W'(got.sending));
         check_field("halted", WORD_W'(want.halted), WORD_W'(got.halted));
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ppsf_req_if req_ch ();
   ppsf_rsp_if rsp_ch ();

   framer_tracker tracker = new();

   bit      calm = 1'b0;          // no idling on either side while set
   bit      hold_request = 1'b0;  // main flow asks for the long hold-off
   int      hold_left = 0;
   int      stall_left = 0;
   int      cycles = 0;
   rsp_type seen_rsp;

   ping_pong_sample_framer dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Hang guard: ends the run if the responses never drain.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("ping_pong_sample_framer_tb failed");
         $finish;
      end
   end

   // Idle length: mostly short, now and then a long one.
   function automatic int gap_len();
      if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Response side ready. Changes at the falling edge only. The long
   // hold-off is counted here so the sender keeps offering meanwhile.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = LONG_HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 30) begin
         stall_left = gap_len() - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Every accepted response goes against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         // concatenation follows the field order of rsp_type
         seen_rsp = {rsp_ch.is_packet_word, rsp_ch.packet_word, rsp_ch.last,
                     rsp_ch.ir_led, rsp_ch.amp_reset, rsp_ch.start_conversion,
                     rsp_ch.busy_led, rsp_ch.sampling_on, rsp_ch.full_flags,
                     rsp_ch.sending, rsp_ch.halted};
         tracker.match_response(seen_rsp);
      end
   end

   // Offer one request, optionally after an idle gap, and hold it until
   // the block takes it. valid stays high into the next call if no gap.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] smp);
      int gap;
      gap = (calm || $urandom_range(0, 99) < 50) ? 0 : gap_len();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid  = 1'b1;
      req_ch.op     = op;
      req_ch.sample = smp;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      tracker.take_request(op, smp);
   endtask

   // Register writes happen only with the block idle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      tracker.set_reg(idx, data);
   endtask

   // Stop offering and wait for every expected response, plus slack.
   task automatic wait_quiet();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (tracker.due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      return SAMPLE_W'($urandom_range(0, 65535));
   endfunction

   // Op mix for the random part. Sample-heavy mode is for long frames.
   // A poll that would read never-stored entries becomes a sample, and an
   // overflow check that would freeze the block becomes a send done; the
   // freeze is saved for the very end.
   function automatic logic [OP_W-1:0] pick_op(input bit sample_heavy);
      int              r;
      logic [OP_W-1:0] op;
      r = $urandom_range(0, 99);
      if (sample_heavy) begin
         if (r < 82)      op = OP_SAMPLE;
         else if (r < 88) op = OP_CMP;
         else if (r < 94) op = OP_POLL;
         else if (r < 98) op = OP_DONE;
         else             op = OP_FRAME;
      end else begin
         if (r < 8)       op = OP_FRAME;
         else if (r < 16) op = OP_SUB;
         else if (r < 30) op = OP_CMP;
         else if (r < 62) op = OP_SAMPLE;
         else if (r < 80) op = OP_POLL;
         else if (r < 86) op = OP_OVF;
         else if (r < 97) op = OP_DONE;
         else             op = OP_UNDEF;
      end
      if (op == OP_POLL && !tracker.poll_is_safe()) op = OP_SAMPLE;
      if (op == OP_OVF && tracker.full_bits == 2'b11) op = OP_DONE;
      return op;
   endfunction

   task automatic run_random(input int count, input bit sample_heavy);
      for (int i = 0; i < count; i++)
         send_request(pick_op(sample_heavy), pick_sample());
   endtask

   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = CSR_HEADER;
      csr_wdata     = '0;
      req_ch.valid  = 1'b0;
      req_ch.op     = OP_FRAME;
      req_ch.sample = '0;
      rsp_ch.ready  = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed, reset settings: every op at least once, both sample extremes,
      // poll and overflow check with nothing full, send done when idle,
      // and the undefined op.
      send_request(OP_SUB, 16'h0000);
      send_request(OP_CMP, 16'h0000);
      send_request(OP_SAMPLE, 16'h0000);
      send_request(OP_FRAME, 16'h0000);
      send_request(OP_CMP, 16'h0000);
      send_request(OP_SAMPLE, 16'hFFFF);
      send_request(OP_POLL, 16'h0000);
      send_request(OP_OVF, 16'h0000);
      send_request(OP_DONE, 16'h0000);
      send_request(OP_UNDEF, 16'hFFFF);
      wait_quiet();

      // Short odd frame so buffers fill quickly; the dead index too.
      write_reg(CSR_HEADER, $urandom());
      write_reg(CSR_TRAILER, $urandom());
      write_reg(CSR_SPF, 32'd3);
      write_reg(CSR_UNUSED, $urandom());

      // Buffer A completes, gate closes: sub tick and compare match are
      // ignored, a sample still lands in B. One full buffer must not
      // freeze. Then B fills, A goes out (odd count, zero high half),
      // a second poll is refused while sending, B goes out after done.
      send_request(OP_CMP, 16'h0000);
      send_request(OP_SAMPLE, pick_sample());
      send_request(OP_SUB, 16'h0000);
      send_request(OP_CMP, 16'h0000);
      send_request(OP_SAMPLE, pick_sample());
      send_request(OP_OVF, 16'h0000);
      send_request(OP_FRAME, 16'h0000);
      send_request(OP_SAMPLE, pick_sample());
      send_request(OP_SAMPLE, pick_sample());
      send_request(OP_POLL, 16'h0000);
      send_request(OP_POLL, 16'h0000);
      send_request(OP_DONE, 16'h0000);
      send_request(OP_POLL, 16'h0000);
      send_request(OP_DONE, 16'h0000);
      wait_quiet();

      // One-sample frames, back to back with no idling anywhere.
      calm = 1'b1;
      write_reg(CSR_SPF, 32'd1);
      run_random(6, 1'b0);
      wait_quiet();
      calm = 1'b0;

      // Extreme header/trailer, zero frame length (counts as one).
      write_reg(CSR_HEADER, 32'h0000_0000);
      write_reg(CSR_TRAILER, 32'hFFFF_FFFF);
      write_reg(CSR_SPF, 32'd0);
      run_random(6, 1'b0);
      wait_quiet();

      // Two-sample frames, then send out whatever is full so the long
      // frame below starts with both buffers empty.
      write_reg(CSR_SPF, 32'd2);
      run_random(6, 1'b0);
      send_request(OP_DONE, 16'h0000);
      send_request(OP_POLL, 16'h0000);
      send_request(OP_DONE, 16'h0000);
      send_request(OP_POLL, 16'h0000);
      send_request(OP_DONE, 16'h0000);
      wait_quiet();

      // Oversized length clamps to the maximum: fill a whole buffer and
      // send the longest packet. The long hold-off starts with the fill
      // while requests keep coming, so the block backs up.
      write_reg(CSR_HEADER, $urandom());
      write_reg(CSR_SPF, 32'd127);
      hold_request = 1'b1;
      while (tracker.full_bits == 2'b00 || !tracker.poll_is_safe())
         send_request(OP_SAMPLE, pick_sample());
      send_request(OP_POLL, 16'h0000);
      send_request(OP_DONE, 16'h0000);
      repeat (4) send_request(OP_SAMPLE, pick_sample());
      wait_quiet();

      // Length lowered below the fill level: next sample flags it full.
      write_reg(CSR_TRAILER, $urandom());
      write_reg(CSR_SPF, 32'd3);
      run_random(6, 1'b0);
      wait_quiet();

      write_reg(CSR_SPF, $urandom_range(3, 9));
      run_random(6, 1'b1);
      wait_quiet();

      // Both buffers full, then the overflow check freezes the block for
      // good; every later request gets a halted status response.
      write_reg(CSR_SPF, 32'd2);
      while (tracker.full_bits != 2'b11)
         send_request(OP_SAMPLE, pick_sample());
      send_request(OP_OVF, 16'h0000);
      send_request(OP_FRAME, 16'h0000);
      send_request(OP_CMP, 16'h0000);
      send_request(OP_SAMPLE, pick_sample());
      send_request(OP_POLL, 16'h0000);
      send_request(OP_DONE, 16'h0000);
      send_request(OP_UNDEF, 16'h0000);
      wait_quiet();

      if (tracker.mismatches == 0)
         $display("ping_pong_sample_framer_tb passed");
      else
         $display("ping_pong_sample_framer_tb failed");
      $finish;
   end

endmodule
